@@ src/cwe_pkg.sv @@
package cwe_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int MAX_KERNEL = 8;

  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_COLS);
  localparam int KW  = $clog2(MAX_KERNEL);
  localparam int ACC_W = 40;

  localparam logic [1:0] KIND_COEFF = 2'd0;
  localparam logic [1:0] KIND_PIXEL = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [2:0] REG_IMAGE_ROWS  = 3'd0;
  localparam logic [2:0] REG_IMAGE_COLS  = 3'd1;
  localparam logic [2:0] REG_KERNEL_ROWS = 3'd2;
  localparam logic [2:0] REG_KERNEL_COLS = 3'd3;
  localparam logic [2:0] REG_FULL_MODE   = 3'd4;
  localparam logic [2:0] REG_PAD_POLICY  = 3'd5;
  localparam logic [2:0] REG_CORRELATE   = 3'd6;
  localparam logic [2:0] REG_PAD_VALUE   = 3'd7;

  localparam logic [1:0] BORDER_FIXED = 2'd2;

  typedef struct packed {
    logic vld;
    logic on_image;
  } mac_ctl_t;

  function automatic logic [6:0] clamp7(input logic [6:0] v, input logic [6:0] hi);
    logic [6:0] r;
    r = v;
    if (v == 7'd0) r = 7'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

@@ src/cwe_mac.sv @@
module cwe_mac import cwe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    clr,
  input  mac_ctl_t                ctl,
  input  logic signed [15:0]      pix,
  input  logic signed [15:0]      border,
  input  logic signed [15:0]      coef,
  output logic signed [ACC_W-1:0] acc,
  output logic                    busy
);

  logic signed [31:0]      prod_r;
  logic                    vld_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [15:0]      opnd;

  assign opnd = ctl.on_image ? pix : border;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      acc_r <= '0;
    end else begin
      vld_r <= ctl.vld;
      if (clr) acc_r <= '0;
      else if (vld_r) acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= opnd * coef;
  end

  assign acc  = acc_r;
  assign busy = vld_r;

endmodule

@@ src/conv2d_window_engine_unit.sv @@
// Channel  | Ports                                        | Accepted when
// input    | in_valid/in_ready, in_kind/row/col/value      | in_valid && in_ready
// result   | out_valid/out_ready, out_value/coord_error    | out_valid && out_ready
// config   | cfg_we, cfg_index, cfg_data                   | cfg_we
// On a store write in_ready stays high.
// A query steps through kernel_rows*kernel_cols taps, each passing the memory read,
// multiplier register and accumulator, then waits in a result register.
// An out-of-range query is shown in the cycle after it is accepted; one multiply-accumulate is shared.
// Reset (rst_n low, synchronous) restores register defaults; stores are not cleared.
// in_ready is low from query accept until its result is taken.
module conv2d_window_engine_unit import cwe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_kind,
  input  logic [6:0]              in_row,
  input  logic [6:0]              in_col,
  input  logic signed [15:0]      in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACC_W-1:0] out_value,
  output logic                    out_coord_error,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CALC  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [6:0] img_rows_r, img_cols_r;
  logic [3:0] k_rows_r, k_cols_r;
  logic       full_r, corr_r;
  logic [1:0] pad_pol_r;
  logic signed [15:0] pad_val_r;

  logic [6:0] h_r, w_r;
  logic [3:0] kh_r, kw_r;
  logic [6:0] qrow_r, qcol_r;
  logic [KW-1:0] u_r, v_r;
  logic       err_r;
  logic signed [15:0] border_r;

  logic signed [15:0] pix_mem [MAX_ROWS*MAX_COLS];
  logic signed [15:0] coef_mem [MAX_KERNEL*MAX_KERNEL];
  logic signed [15:0] pix_q, coef_q;
  mac_ctl_t ctl_r;

  logic accept, is_query, mac_busy, last_tap, issue, on_image;
  logic [6:0] hq, wq;
  logic [3:0] khq, kwq;
  logic [7:0] oh, ow;
  logic signed [8:0] pr, pc;
  logic [3:0] cu, cv;
  logic signed [ACC_W-1:0] acc;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_query = accept && (in_kind == KIND_QUERY);

  // Clamped sizes and output bounds for the incoming query
  always_comb begin
    hq  = clamp7(img_rows_r, 7'(MAX_ROWS));
    wq  = clamp7(img_cols_r, 7'(MAX_COLS));
    khq = 4'(clamp7({3'd0, k_rows_r}, 7'(MAX_KERNEL)));
    kwq = 4'(clamp7({3'd0, k_cols_r}, 7'(MAX_KERNEL)));
    oh  = full_r ? 8'({1'b0, hq} + {4'd0, khq} - 8'd1) : {1'b0, hq};
    ow  = full_r ? 8'({1'b0, wq} + {4'd0, kwq} - 8'd1) : {1'b0, wq};
  end

  assign issue    = (state_r == ST_CALC);
  assign last_tap = ({1'b0, u_r} == kh_r - 4'd1) && ({1'b0, v_r} == kw_r - 4'd1);

  // Pixel position and kernel tap of the current window step
  always_comb begin
    if (full_r) begin
      pr = $signed({2'b00, qrow_r}) - $signed({5'd0, 1'b0, u_r});
      pc = $signed({2'b00, qcol_r}) - $signed({5'd0, 1'b0, v_r});
    end else begin
      pr = $signed({2'b00, qrow_r}) + $signed({5'd0, 1'b0, u_r})
         - $signed({5'd0, 1'b0, kh_r[3:1]});
      pc = $signed({2'b00, qcol_r}) + $signed({5'd0, 1'b0, v_r})
         - $signed({5'd0, 1'b0, kw_r[3:1]});
    end
    on_image = (pr >= 0) && (pc >= 0) && (pr < $signed({2'b00, h_r}))
            && (pc < $signed({2'b00, w_r}));
    cu = corr_r ? {1'b0, u_r} : 4'(kh_r - 4'd1 - {1'b0, u_r});
    cv = corr_r ? {1'b0, v_r} : 4'(kw_r - 4'd1 - {1'b0, v_r});
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_PIXEL && in_row < 7'(MAX_ROWS) && in_col < 7'(MAX_COLS))
      pix_mem[{in_row[RW-1:0], in_col[CW-1:0]}] <= in_value;
    pix_q <= pix_mem[{pr[RW-1:0], pc[CW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_COEFF && in_row < 7'(MAX_KERNEL)
        && in_col < 7'(MAX_KERNEL))
      coef_mem[{in_row[KW-1:0], in_col[KW-1:0]}] <= in_value;
    coef_q <= coef_mem[{cu[KW-1:0], cv[KW-1:0]}];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (is_query)
          state_nxt = ({1'b0, in_row} >= oh || {1'b0, in_col} >= ow) ? ST_OUT : ST_CALC;
      end
      ST_CALC:  if (last_tap) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!ctl_r.vld && !mac_busy) state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      img_rows_r <= 7'd64;
      img_cols_r <= 7'd64;
      k_rows_r   <= 4'd3;
      k_cols_r   <= 4'd3;
      full_r     <= 1'b0;
      pad_pol_r  <= 2'd0;
      corr_r     <= 1'b0;
      pad_val_r  <= '0;
      ctl_r      <= '0;
      err_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctl_r.vld      <= issue;
      ctl_r.on_image <= on_image;
      if (is_query)
        err_r <= ({1'b0, in_row} >= oh || {1'b0, in_col} >= ow);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_ROWS:  img_rows_r <= cfg_data[6:0];
          REG_IMAGE_COLS:  img_cols_r <= cfg_data[6:0];
          REG_KERNEL_ROWS: k_rows_r   <= cfg_data[3:0];
          REG_KERNEL_COLS: k_cols_r   <= cfg_data[3:0];
          REG_FULL_MODE:   full_r     <= cfg_data[0];
          REG_PAD_POLICY:  pad_pol_r  <= cfg_data[1:0];
          REG_CORRELATE:   corr_r     <= cfg_data[0];
          REG_PAD_VALUE:   pad_val_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Latch query context; step the window row by row
  always_ff @(posedge clk) begin
    if (is_query) begin
      h_r      <= hq;
      w_r      <= wq;
      kh_r     <= khq;
      kw_r     <= kwq;
      qrow_r   <= in_row;
      qcol_r   <= in_col;
      u_r      <= '0;
      v_r      <= '0;
      border_r <= (!full_r && pad_pol_r == BORDER_FIXED) ? pad_val_r : 16'sd0;
    end else if (issue) begin
      if ({1'b0, v_r} == kw_r - 4'd1) begin
        v_r <= '0;
        u_r <= u_r + 1'b1;
      end else begin
        v_r <= v_r + 1'b1;
      end
    end
  end

  cwe_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (is_query),
    .ctl    (ctl_r),
    .pix    (pix_q),
    .border (border_r),
    .coef   (coef_q),
    .acc    (acc),
    .busy   (mac_busy)
  );

  assign out_valid       = (state_r == ST_OUT);
  assign out_value       = acc;
  assign out_coord_error = err_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_coord_error |-> out_value == '0)
    else $error("flagged result carries a nonzero sum");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !ctl_r.vld && !mac_busy)
    else $error("result shown while the accumulator is still busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value))
    else $error("result changed before it was taken");

endmodule
